### rtl/rfae_pkg.sv
// shared types and constants for the register file alu executor
// no dependencies; every other rtl file except rfae_ram refers to this package by scoped names
`default_nettype none

package rfae_pkg;

  // defaults for the top level parameters
  localparam int NUM_REGS_DEF   = 32;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed field widths of the channels
  localparam int REG_NUM_W = 5;
  localparam int KIND_W    = 5;
  localparam int IMM_W     = 12;
  localparam int SHAMT_W   = 5;
  localparam int VALUE_W   = 32;

  // register that always reads zero
  localparam logic [REG_NUM_W-1:0] ZERO_REG = 5'd31;

  // operation kinds of the input instruction
  typedef enum logic [KIND_W-1:0] {
    K_ADD   = 5'd0,
    K_ADDI  = 5'd1,
    K_AND   = 5'd2,
    K_ANDI  = 5'd3,
    K_ORR   = 5'd4,
    K_ORRI  = 5'd5,
    K_EOR   = 5'd6,
    K_EORI  = 5'd7,
    K_SUB   = 5'd8,
    K_SUBI  = 5'd9,
    K_LSL   = 5'd10,
    K_LSR   = 5'd11,
    K_MUL   = 5'd12,
    K_UDIV  = 5'd13,
    K_SDIV  = 5'd14,
    K_SMULH = 5'd15,
    K_UMULH = 5'd16
  } kind_e;

  // operations of the iterative multiply/divide unit
  typedef enum logic [2:0] {
    MD_MUL,
    MD_UMULH,
    MD_SMULH,
    MD_UDIV,
    MD_SDIV
  } md_op_e;

  typedef struct packed {
    logic   start;
    md_op_e op;
  } md_ctrl_t;

  typedef struct packed {
    logic done;
    logic div_by_zero;
  } md_stat_t;

endpackage

`default_nettype wire

### rtl/rfae_in_if.sv
// instruction channel: valid/ready handshake with the decoded instruction fields
// depends on rfae_pkg for field widths
`default_nettype none

interface rfae_in_if;
  logic                            valid;
  logic                            ready;
  logic [rfae_pkg::KIND_W-1:0]     kind;
  logic [rfae_pkg::REG_NUM_W-1:0]  dest_reg;
  logic [rfae_pkg::REG_NUM_W-1:0]  src_a_reg;
  logic [rfae_pkg::REG_NUM_W-1:0]  src_b_reg;
  logic [rfae_pkg::IMM_W-1:0]      imm;

  modport source (output valid, kind, dest_reg, src_a_reg, src_b_reg, imm, input ready);
  modport sink   (input valid, kind, dest_reg, src_a_reg, src_b_reg, imm, output ready);
endinterface

`default_nettype wire

### rtl/rfae_out_if.sv
// result channel: valid/ready handshake with the writeback report
// depends on rfae_pkg for field widths
`default_nettype none

interface rfae_out_if;
  logic                            valid;
  logic                            ready;
  logic [rfae_pkg::REG_NUM_W-1:0]  written_reg;
  logic [rfae_pkg::VALUE_W-1:0]    written_value;
  logic                            div_by_zero;

  modport source (output valid, written_reg, written_value, div_by_zero, input ready);
  modport sink   (input valid, written_reg, written_value, div_by_zero, output ready);
endinterface

`default_nettype wire

### rtl/rfae_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module rfae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic                             re_i,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic      [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/rfae_muldiv.sv
// iterative radix-2 multiply / divide unit, one bit per cycle
// shift-add multiply with high-word signed correction, restoring divide
// depends on rfae_pkg
`default_nettype none

module rfae_muldiv #(
  parameter int DATA_WIDTH = rfae_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire rfae_pkg::md_ctrl_t      ctrl_i,
  input  wire logic [DATA_WIDTH-1:0]   a_i,
  input  wire logic [DATA_WIDTH-1:0]   b_i,
  output rfae_pkg::md_stat_t           stat_o,
  output logic      [DATA_WIDTH-1:0]   result_o
);

  localparam int CW = $clog2(DATA_WIDTH + 1);

  typedef enum logic [1:0] {
    M_IDLE,
    M_RUN,
    M_FIX
  } state_e;

  state_e                 state_q;
  rfae_pkg::md_op_e       op_q;
  logic [DATA_WIDTH-1:0]  r_q;      // high product word or partial remainder
  logic [DATA_WIDTH-1:0]  x_q;      // multiplier / low word, or dividend / quotient
  logic [DATA_WIDTH-1:0]  y_q;      // multiplicand or divisor
  logic [DATA_WIDTH-1:0]  corr_q;
  logic                   neg_q;
  logic                   dz_q;
  logic                   done_q;
  logic [CW-1:0]          cnt_q;
  logic [DATA_WIDTH-1:0]  res_q;

  logic                   a_neg, b_neg, start_div, run_div;
  logic [DATA_WIDTH-1:0]  a_mag, b_mag, corr_a, corr_b, fix_res;
  logic [DATA_WIDTH:0]    mul_sum;
  logic [DATA_WIDTH:0]    rem_sh;
  logic [DATA_WIDTH+1:0]  div_diff;
  logic                   borrow;

  // operand signs and magnitudes at start
  always_comb begin
    a_neg     = a_i[DATA_WIDTH-1];
    b_neg     = b_i[DATA_WIDTH-1];
    a_mag     = a_neg ? (~a_i + 1'b1) : a_i;
    b_mag     = b_neg ? (~b_i + 1'b1) : b_i;
    start_div = (ctrl_i.op == rfae_pkg::MD_UDIV) || (ctrl_i.op == rfae_pkg::MD_SDIV);
    corr_a    = (ctrl_i.op == rfae_pkg::MD_SMULH && a_neg) ? b_i : '0;
    corr_b    = (ctrl_i.op == rfae_pkg::MD_SMULH && b_neg) ? a_i : '0;
    run_div   = (op_q == rfae_pkg::MD_UDIV) || (op_q == rfae_pkg::MD_SDIV);
  end

  // one step of shift-add multiply and restoring divide
  always_comb begin
    mul_sum  = {1'b0, r_q} + (x_q[0] ? {1'b0, y_q} : '0);
    rem_sh   = {r_q, x_q[DATA_WIDTH-1]};
    div_diff = {1'b0, rem_sh} - {2'b00, y_q};
    borrow   = div_diff[DATA_WIDTH+1];
  end

  // final result selection and sign fixup
  always_comb begin
    case (op_q)
      rfae_pkg::MD_MUL:   fix_res = x_q;
      rfae_pkg::MD_UMULH: fix_res = r_q;
      rfae_pkg::MD_SMULH: fix_res = r_q - corr_q;
      rfae_pkg::MD_UDIV:  fix_res = x_q;
      rfae_pkg::MD_SDIV:  fix_res = neg_q ? (~x_q + 1'b1) : x_q;
      default:            fix_res = '0;
    endcase
    if (dz_q) begin
      fix_res = '0;
    end
  end

  // sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_q  <= 1'b0;
      dz_q    <= 1'b0;
    end else begin
      done_q <= (state_q == M_FIX);
      case (state_q)
        M_IDLE: begin
          if (ctrl_i.start) begin
            op_q   <= ctrl_i.op;
            corr_q <= corr_a + corr_b;
            neg_q  <= a_neg ^ b_neg;
            r_q    <= '0;
            cnt_q  <= CW'(DATA_WIDTH);
            if (start_div) begin
              x_q <= (ctrl_i.op == rfae_pkg::MD_SDIV) ? a_mag : a_i;
              y_q <= (ctrl_i.op == rfae_pkg::MD_SDIV) ? b_mag : b_i;
            end else begin
              x_q <= b_i;
              y_q <= a_i;
            end
            if (start_div && b_i == '0) begin
              dz_q    <= 1'b1;
              state_q <= M_FIX;
            end else begin
              dz_q    <= 1'b0;
              state_q <= M_RUN;
            end
          end
        end
        M_RUN: begin
          if (run_div) begin
            r_q <= borrow ? rem_sh[DATA_WIDTH-1:0] : div_diff[DATA_WIDTH-1:0];
            x_q <= {x_q[DATA_WIDTH-2:0], ~borrow};
          end else begin
            r_q <= mul_sum[DATA_WIDTH:1];
            x_q <= {mul_sum[0], x_q[DATA_WIDTH-1:1]};
          end
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CW'(1)) begin
            state_q <= M_FIX;
          end
        end
        M_FIX: begin
          res_q   <= fix_res;
          state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  assign stat_o.done        = done_q;
  assign stat_o.div_by_zero = dz_q;
  assign result_o           = res_q;

endmodule

`default_nettype wire

### rtl/register_file_alu_executor_top.sv
// top level: register file in two ram copies, alu and iterative multiply/divide
// depends on rfae_pkg, rfae_in_if, rfae_out_if, rfae_ram, rfae_muldiv
`default_nettype none

// Executes one decoded register instruction at a time against a file of
// NUM_REGS registers of DATA_WIDTH bits, cleared at reset, and reports the
// destination, the written value (low 32 bits) and a divide-by-zero flag.
// The register file sits in two identical synchronous rams, one per source
// operand, written together at writeback; a per-register valid bit makes a
// register that was never written read as zero, so no clearing pass is needed.
// Register 31 and numbers at or above NUM_REGS read zero and drop writes.
// Add, logic, subtract and shift instructions go from transfer in through the
// read, execute and done states to the output register, one item at a time;
// mul, udiv, sdiv, smulh and umulh also wait on the radix-2 multiply/divide
// unit, which retires one bit per cycle. The result waits in an output
// register, so the next instruction is taken before it has been transferred.
module register_file_alu_executor_top #(
  parameter int NUM_REGS   = rfae_pkg::NUM_REGS_DEF,
  parameter int DATA_WIDTH = rfae_pkg::DATA_WIDTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rfae_in_if.sink    in_i,
  rfae_out_if.source out_o
);

  localparam int AW = $clog2(NUM_REGS);
  localparam int RW = rfae_pkg::REG_NUM_W;
  localparam logic [RW:0] NUM_REGS_C = (RW + 1)'(NUM_REGS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_WAIT,
    S_DONE
  } state_e;

  state_e                       state_q;
  rfae_pkg::kind_e              kind_q;
  logic [RW-1:0]                dest_q;
  logic [rfae_pkg::IMM_W-1:0]   imm_q;
  logic                         a_zero_q, b_zero_q, dest_ok_q, wr_ok_q;
  logic [DATA_WIDTH-1:0]        a_q, b_q, res_q;
  logic                         dz_q;
  logic [NUM_REGS-1:0]          valid_q;
  logic                         out_valid_q;
  logic [RW-1:0]                out_reg_q;
  logic [rfae_pkg::VALUE_W-1:0] out_val_q;
  logic                         out_dz_q;

  logic                         accept, out_free, a_zero, b_zero, dest_ok, ram_we;
  logic [DATA_WIDTH-1:0]        rdata_a, rdata_b, imm_w, alu_res, md_res;
  logic                         is_md, kind_ok;
  rfae_pkg::md_op_e             md_op;
  rfae_pkg::md_ctrl_t           md_ctrl;
  rfae_pkg::md_stat_t           md_stat;

  // input transfer and register number checks
  always_comb begin
    accept  = in_i.valid && (state_q == S_IDLE);
    a_zero  = ({1'b0, in_i.src_a_reg} >= NUM_REGS_C) || (in_i.src_a_reg == rfae_pkg::ZERO_REG)
              || !valid_q[in_i.src_a_reg[AW-1:0]];
    b_zero  = ({1'b0, in_i.src_b_reg} >= NUM_REGS_C) || (in_i.src_b_reg == rfae_pkg::ZERO_REG)
              || !valid_q[in_i.src_b_reg[AW-1:0]];
    dest_ok = ({1'b0, in_i.dest_reg} < NUM_REGS_C) && (in_i.dest_reg != rfae_pkg::ZERO_REG);
  end

  assign in_i.ready = (state_q == S_IDLE);

  // writeback lands before the next instruction is read, so no forwarding
  assign out_free = !out_valid_q || out_o.ready;
  assign ram_we   = (state_q == S_DONE) && out_free && wr_ok_q && dest_ok_q;

  rfae_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (NUM_REGS)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (dest_q[AW-1:0]),
    .wdata_i (res_q),
    .re_i    (accept),
    .raddr_i (in_i.src_a_reg[AW-1:0]),
    .rdata_o (rdata_a)
  );

  rfae_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (NUM_REGS)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (dest_q[AW-1:0]),
    .wdata_i (res_q),
    .re_i    (accept),
    .raddr_i (in_i.src_b_reg[AW-1:0]),
    .rdata_o (rdata_b)
  );

  // combinational alu and decode of operations for the multiply/divide unit
  always_comb begin
    imm_w   = DATA_WIDTH'(imm_q);
    alu_res = '0;
    is_md   = 1'b0;
    kind_ok = 1'b1;
    md_op   = rfae_pkg::MD_MUL;
    case (kind_q)
      rfae_pkg::K_ADD:   alu_res = a_q + b_q;
      rfae_pkg::K_ADDI:  alu_res = a_q + imm_w;
      rfae_pkg::K_AND:   alu_res = a_q & b_q;
      rfae_pkg::K_ANDI:  alu_res = a_q & imm_w;
      rfae_pkg::K_ORR:   alu_res = a_q | b_q;
      rfae_pkg::K_ORRI:  alu_res = a_q | imm_w;
      rfae_pkg::K_EOR:   alu_res = a_q ^ b_q;
      rfae_pkg::K_EORI:  alu_res = a_q ^ imm_w;
      rfae_pkg::K_SUB:   alu_res = a_q - b_q;
      rfae_pkg::K_SUBI:  alu_res = a_q - imm_w;
      rfae_pkg::K_LSL:   alu_res = a_q << imm_q[rfae_pkg::SHAMT_W-1:0];
      rfae_pkg::K_LSR:   alu_res = a_q >> imm_q[rfae_pkg::SHAMT_W-1:0];
      rfae_pkg::K_MUL: begin
        is_md = 1'b1;
        md_op = rfae_pkg::MD_MUL;
      end
      rfae_pkg::K_UDIV: begin
        is_md = 1'b1;
        md_op = rfae_pkg::MD_UDIV;
      end
      rfae_pkg::K_SDIV: begin
        is_md = 1'b1;
        md_op = rfae_pkg::MD_SDIV;
      end
      rfae_pkg::K_SMULH: begin
        is_md = 1'b1;
        md_op = rfae_pkg::MD_SMULH;
      end
      rfae_pkg::K_UMULH: begin
        is_md = 1'b1;
        md_op = rfae_pkg::MD_UMULH;
      end
      default: kind_ok = 1'b0;
    endcase
    md_ctrl.start = (state_q == S_EXEC) && is_md;
    md_ctrl.op    = md_op;
  end

  rfae_muldiv #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (md_ctrl),
    .a_i      (a_q),
    .b_i      (b_q),
    .stat_o   (md_stat),
    .result_o (md_res)
  );

  // instruction sequencer, valid bits and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result in S_DONE replaces the one leaving in the same cycle
      if (out_valid_q && out_o.ready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            kind_q    <= rfae_pkg::kind_e'(in_i.kind);
            dest_q    <= in_i.dest_reg;
            imm_q     <= in_i.imm;
            a_zero_q  <= a_zero;
            b_zero_q  <= b_zero;
            dest_ok_q <= dest_ok;
            state_q   <= S_READ;
          end
        end
        S_READ: begin
          a_q     <= a_zero_q ? '0 : rdata_a;
          b_q     <= b_zero_q ? '0 : rdata_b;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          wr_ok_q <= kind_ok;
          dz_q    <= 1'b0;
          res_q   <= alu_res;
          if (is_md) begin
            state_q <= S_WAIT;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_WAIT: begin
          if (md_stat.done) begin
            res_q   <= md_res;
            dz_q    <= md_stat.div_by_zero;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_reg_q   <= wr_ok_q ? dest_q : rfae_pkg::ZERO_REG;
            out_val_q   <= rfae_pkg::VALUE_W'(res_q);
            out_dz_q    <= dz_q;
            if (wr_ok_q && dest_ok_q) begin
              valid_q[dest_q[AW-1:0]] <= 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.written_reg   = out_reg_q;
  assign out_o.written_value = out_val_q;
  assign out_o.div_by_zero   = out_dz_q;

endmodule

`default_nettype wire
